// ===== sv/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority task table package
// Shared widths, opcodes, status codes and the scan result flags.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

   localparam int unsigned CAPACITY_DEF = 64;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned TASK_W   = 16;
   localparam int unsigned OWNER_W  = 16;
   localparam int unsigned PRIO_W   = 32;
   localparam int unsigned WORD_W   = TASK_W + OWNER_W + PRIO_W;
   localparam int unsigned KEY_W    = PRIO_W + TASK_W;

   localparam int unsigned REQ_TDATA_W = OWNER_W + TASK_W + PRIO_W;
   localparam int unsigned RSP_TDATA_W = OWNER_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_EDIT   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_EXEC   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic match_hit;
      logic free_hit;
      logic best_hit;
   } scan_flags_type;

endpackage

`default_nettype wire

// ===== sv/ptt_ram.sv =====
// ----------------------------------------------------------------------------
// Priority task table RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/ptt_scan.sv =====
// ----------------------------------------------------------------------------
// Priority task table scan unit
// Walks the entries one per cycle: finds the key, the lowest free entry and
// the entry with the highest priority and task id using one comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_scan #(
   parameter int unsigned CAPACITY = ptt_pkg::CAPACITY_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear,
   input  wire logic                          strobe,
   input  wire logic [$clog2(CAPACITY)-1:0]   ent_idx,
   input  wire logic                          ent_valid,
   input  wire logic [ptt_pkg::WORD_W-1:0]    ent_word,
   input  wire logic [ptt_pkg::TASK_W-1:0]    key,
   output ptt_pkg::scan_flags_type            flags,
   output logic      [$clog2(CAPACITY)-1:0]   match_idx,
   output logic      [ptt_pkg::OWNER_W-1:0]   match_owner,
   output logic      [$clog2(CAPACITY)-1:0]   free_idx,
   output logic      [$clog2(CAPACITY)-1:0]   best_idx,
   output logic      [ptt_pkg::OWNER_W-1:0]   best_owner
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);

   logic [ptt_pkg::TASK_W-1:0]  ent_task;
   logic [ptt_pkg::OWNER_W-1:0] ent_owner;
   logic [ptt_pkg::PRIO_W-1:0]  ent_prio;
   logic [ptt_pkg::KEY_W-1:0]   ent_rank;
   logic                        ent_wins;

   ptt_pkg::scan_flags_type     flags_ff, flags_in;
   logic [IDX_W-1:0]            match_idx_ff, match_idx_in;
   logic [ptt_pkg::OWNER_W-1:0] match_owner_ff, match_owner_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic [ptt_pkg::OWNER_W-1:0] best_owner_ff, best_owner_in;
   logic [ptt_pkg::KEY_W-1:0]   best_rank_ff, best_rank_in;

   assign ent_task  = ent_word[ptt_pkg::TASK_W-1:0];
   assign ent_owner = ent_word[ptt_pkg::TASK_W +: ptt_pkg::OWNER_W];
   assign ent_prio  = ent_word[ptt_pkg::TASK_W + ptt_pkg::OWNER_W +: ptt_pkg::PRIO_W];
   assign ent_rank  = {ent_prio, ent_task};
   assign ent_wins  = ent_rank > best_rank_ff;

   always_comb begin
      flags_in       = flags_ff;
      match_idx_in   = match_idx_ff;
      match_owner_in = match_owner_ff;
      free_idx_in    = free_idx_ff;
      best_idx_in    = best_idx_ff;
      best_owner_in  = best_owner_ff;
      best_rank_in   = best_rank_ff;
      if (clear) begin
         flags_in = '0;
      end else if (strobe) begin
         if (ent_valid && ent_task == key) begin
            flags_in.match_hit = 1'b1;
            match_idx_in       = ent_idx;
            match_owner_in     = ent_owner;
         end
         if (!ent_valid && !flags_ff.free_hit) begin
            flags_in.free_hit = 1'b1;
            free_idx_in       = ent_idx;
         end
         if (ent_valid && (!flags_ff.best_hit || ent_wins)) begin
            flags_in.best_hit = 1'b1;
            best_idx_in       = ent_idx;
            best_owner_in     = ent_owner;
            best_rank_in      = ent_rank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      match_idx_ff   <= match_idx_in;
      match_owner_ff <= match_owner_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_owner_ff  <= best_owner_in;
      best_rank_ff   <= best_rank_in;
   end

   assign flags       = flags_ff;
   assign match_idx   = match_idx_ff;
   assign match_owner = match_owner_ff;
   assign free_idx    = free_idx_ff;
   assign best_idx    = best_idx_ff;
   assign best_owner  = best_owner_ff;

endmodule

`default_nettype wire

// ===== sv/priority_task_table_core.sv =====
// ----------------------------------------------------------------------------
// Priority task table core
// Table of pending tasks with add, edit, remove and execute-top requests.
//
// Each request on the req_ channel carries an opcode in tuser and the owner,
// task id and priority in tdata. Every request returns exactly one response
// on the rsp_ channel with a status code in tuser and the served owner in
// tdata. A request scans all CAPACITY entries through one read port and one
// comparator, one entry per cycle, then passes the drain and done states;
// the table update and the registered response follow in the done state,
// and only then is the next request taken. The scan length is set by the
// single read port of the entry memory. After reset a clearing pass over
// all CAPACITY entries empties the valid memory, and req_tready stays low
// meanwhile. A response waits in an output register while the receiver
// stalls; the next request is accepted and scanned, and its table update is
// held back until the previous response has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_table_core #(
   parameter int unsigned CAPACITY = ptt_pkg::CAPACITY_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: owner_id, task_key, prio_value.
   input  wire logic [ptt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // Fields from bit 0: opcode.
   input  wire logic [ptt_pkg::OP_W-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // Fields from bit 0: served_owner.
   output logic      [ptt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Fields from bit 0: status.
   output logic      [ptt_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            addr_ff, addr_in;
   logic                        rd_strobe_ff, rd_strobe_in;
   logic [IDX_W-1:0]            rd_idx_ff;
   ptt_pkg::opcode_type         op_ff, op_in;
   logic [ptt_pkg::OWNER_W-1:0] owner_ff, owner_in;
   logic [ptt_pkg::TASK_W-1:0]  key_ff, key_in;
   logic [ptt_pkg::PRIO_W-1:0]  prio_ff, prio_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ptt_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [ptt_pkg::OWNER_W-1:0] rsp_owner_ff, rsp_owner_in;

   logic                        req_fire;
   logic                        out_free;
   logic                        commit;
   ptt_pkg::status_type         status_c;
   logic [ptt_pkg::OWNER_W-1:0] served_c;
   logic                        dwr_en;
   logic [IDX_W-1:0]            dwr_addr;
   logic [ptt_pkg::WORD_W-1:0]  dwr_data;
   logic                        vwr_en;
   logic [IDX_W-1:0]            vwr_addr;
   logic                        vwr_bit;
   logic                        upd_en;
   logic [IDX_W-1:0]            upd_addr;
   logic                        upd_bit;

   logic [ptt_pkg::WORD_W-1:0]  rd_word;
   logic                        rd_valid;

   ptt_pkg::scan_flags_type     flags;
   logic [IDX_W-1:0]            match_idx;
   logic [ptt_pkg::OWNER_W-1:0] match_owner;
   logic [IDX_W-1:0]            free_idx;
   logic [IDX_W-1:0]            best_idx;
   logic [ptt_pkg::OWNER_W-1:0] best_owner;

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = state_ff == S_DONE && out_free;

   ptt_ram #(
      .WIDTH (ptt_pkg::WORD_W),
      .DEPTH (CAPACITY)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (dwr_en),
      .wr_addr (dwr_addr),
      .wr_data (dwr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   ptt_ram #(
      .WIDTH (1),
      .DEPTH (CAPACITY)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vwr_en),
      .wr_addr (vwr_addr),
      .wr_data (vwr_bit),
      .rd_addr (addr_ff),
      .rd_data (rd_valid)
   );

   ptt_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (req_fire),
      .strobe      (rd_strobe_ff),
      .ent_idx     (rd_idx_ff),
      .ent_valid   (rd_valid),
      .ent_word    (rd_word),
      .key         (key_ff),
      .flags       (flags),
      .match_idx   (match_idx),
      .match_owner (match_owner),
      .free_idx    (free_idx),
      .best_idx    (best_idx),
      .best_owner  (best_owner)
   );

   always_comb begin
      status_c = ptt_pkg::ST_OK;
      served_c = '0;
      dwr_en   = 1'b0;
      dwr_addr = match_idx;
      dwr_data = {prio_ff, owner_ff, key_ff};
      upd_en   = 1'b0;
      upd_addr = match_idx;
      upd_bit  = 1'b0;
      unique case (op_ff)
         ptt_pkg::OP_ADD: begin
            if (flags.match_hit || flags.free_hit) begin
               dwr_en   = 1'b1;
               dwr_addr = flags.match_hit ? match_idx : free_idx;
               upd_en   = 1'b1;
               upd_addr = dwr_addr;
               upd_bit  = 1'b1;
            end else begin
               status_c = ptt_pkg::ST_FULL;
            end
         end
         ptt_pkg::OP_EDIT: begin
            if (flags.match_hit) begin
               dwr_en   = 1'b1;
               dwr_data = {prio_ff, match_owner, key_ff};
            end else begin
               status_c = ptt_pkg::ST_NOT_FOUND;
            end
         end
         ptt_pkg::OP_REMOVE: begin
            if (flags.match_hit) begin
               upd_en = 1'b1;
            end else begin
               status_c = ptt_pkg::ST_NOT_FOUND;
            end
         end
         ptt_pkg::OP_EXEC: begin
            if (flags.best_hit) begin
               upd_en   = 1'b1;
               upd_addr = best_idx;
               served_c = best_owner;
            end else begin
               status_c = ptt_pkg::ST_EMPTY;
            end
         end
         default: begin
            status_c = ptt_pkg::ST_OK;
         end
      endcase
      dwr_en = dwr_en && commit;
      if (state_ff == S_CLEAR) begin
         vwr_en   = 1'b1;
         vwr_addr = addr_ff;
         vwr_bit  = 1'b0;
      end else begin
         vwr_en   = upd_en && commit;
         vwr_addr = upd_addr;
         vwr_bit  = upd_bit;
      end
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      rd_strobe_in  = 1'b0;
      op_in         = op_ff;
      owner_in      = owner_ff;
      key_in        = key_ff;
      prio_in       = prio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in  = rsp_owner_ff;
      unique case (state_ff)
         S_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = ptt_pkg::opcode_type'(req_tuser);
               owner_in = req_tdata[ptt_pkg::OWNER_W-1:0];
               key_in   = req_tdata[ptt_pkg::OWNER_W +: ptt_pkg::TASK_W];
               prio_in  = req_tdata[ptt_pkg::OWNER_W + ptt_pkg::TASK_W +: ptt_pkg::PRIO_W];
               addr_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_strobe_in = 1'b1;
            addr_in      = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_c;
               rsp_owner_in  = served_c;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         rd_strobe_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_strobe_ff <= rd_strobe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= addr_ff;
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      key_ff        <= key_in;
      prio_ff       <= prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owner_ff  <= rsp_owner_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_owner_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire
